// File: design/arbkf_pkg.sv
`timescale 1ns / 1ps

package arbkf_pkg;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_DIV,
    ST_WB
  } seq_state_t;

  // Micro-operations of the shared arithmetic unit.
  typedef enum logic [2:0] {
    OP_ADD,   // saturating add
    OP_SUB,   // saturating subtract
    OP_MUL,   // Q16.16 product, rounded and saturated
    OP_SCL,   // exact integer product, saturated
    OP_DIV,   // Q16.16 quotient, rounded and saturated
    OP_ANG,   // latch the angle estimate for the result
    OP_FIN,   // send the result and finish the sample
    OP_LOAD   // finish the first sample, no result
  } op_t;

  localparam int ADDR_W = 6;
  localparam int NUM_REGS = 33;
  localparam int PC_W = 8;
  localparam int PROG_LEN = 179;
  localparam int DIV_STEPS = 48;
  localparam int DIV_W = 6;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    op_t   op;
    addr_t dst;
    addr_t a;
    addr_t b;
  } instr_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_GYRO_NOISE   = 3'd0;
  localparam logic [2:0] CFG_ANGLE_NOISE  = 3'd1;
  localparam logic [2:0] CFG_ACCEL_NOISE  = 3'd2;
  localparam logic [2:0] CFG_BIAS_NOISE   = 3'd3;
  localparam logic [2:0] CFG_RATE_INIT    = 3'd4;
  localparam logic [2:0] CFG_BIAS_INIT    = 3'd5;
  localparam logic [2:0] CFG_SAMPLE_PER   = 3'd6;

  // Register file slots.
  localparam addr_t A_RR  = 6'd0;
  localparam addr_t A_RA  = 6'd1;
  localparam addr_t A_RB  = 6'd2;
  localparam addr_t A_AA  = 6'd3;
  localparam addr_t A_AB  = 6'd4;
  localparam addr_t A_BB  = 6'd5;
  localparam addr_t A_ER  = 6'd6;
  localparam addr_t A_EA  = 6'd7;
  localparam addr_t A_EB  = 6'd8;
  localparam addr_t A_T1  = 6'd9;
  localparam addr_t A_T2  = 6'd10;
  localparam addr_t A_T3  = 6'd11;
  localparam addr_t A_U   = 6'd12;
  localparam addr_t A_V   = 6'd13;
  localparam addr_t A_X   = 6'd14;
  localparam addr_t A_Y   = 6'd15;
  localparam addr_t A_D   = 6'd16;
  localparam addr_t A_E   = 6'd17;
  localparam addr_t A_GR  = 6'd18;
  localparam addr_t A_GA  = 6'd19;
  localparam addr_t A_GB  = 6'd20;
  localparam addr_t A_G1  = 6'd21;
  localparam addr_t A_GB1 = 6'd22;
  localparam addr_t A_GA2 = 6'd23;
  localparam addr_t A_G2  = 6'd24;
  localparam addr_t A_N   = 6'd25;
  localparam addr_t A_S   = 6'd26;
  localparam addr_t A_NRR = 6'd27;
  localparam addr_t A_NRA = 6'd28;
  localparam addr_t A_NRB = 6'd29;
  localparam addr_t A_NAA = 6'd30;
  localparam addr_t A_NAB = 6'd31;
  localparam addr_t A_NBB = 6'd32;

  // Operand sources outside the register file.
  localparam addr_t A_SPECIAL = 6'd48;
  localparam addr_t A_T     = 6'd48;
  localparam addr_t A_QW    = 6'd49;
  localparam addr_t A_RT    = 6'd50;
  localparam addr_t A_RTQ   = 6'd51;
  localparam addr_t A_RW    = 6'd52;
  localparam addr_t A_QB    = 6'd53;
  localparam addr_t A_PW    = 6'd54;
  localparam addr_t A_PB    = 6'd55;
  localparam addr_t A_ONE   = 6'd56;
  localparam addr_t A_HALF  = 6'd57;
  localparam addr_t A_THIRD = 6'd58;
  localparam addr_t A_TWO   = 6'd59;
  localparam addr_t A_ZERO  = 6'd60;
  localparam addr_t A_Z     = 6'd61;
  localparam addr_t A_W     = 6'd62;

  localparam logic [31:0] Q_ONE   = 32'd65536;
  localparam logic [31:0] Q_HALF  = 32'd32768;
  localparam logic [31:0] Q_THIRD = 32'd21845;

  localparam logic [PC_W-1:0] PC_INIT = 8'd0;
  localparam logic [PC_W-1:0] PC_MAIN = 8'd12;

  function automatic instr_t mk(input op_t op, input addr_t d, input addr_t a, input addr_t b);
    instr_t r;
    r.op  = op;
    r.dst = d;
    r.a   = a;
    r.b   = b;
    return r;
  endfunction

  // Signed magnitude to saturated 32-bit two's complement.
  function automatic logic [31:0] from_mag(input logic neg, input logic [47:0] m);
    logic [31:0] r;
    if (neg) begin
      if (m > 48'h0000_8000_0000) r = 32'h8000_0000;
      else r = ~m[31:0] + 32'd1;
    end else begin
      if (m > 48'h0000_7fff_ffff) r = 32'h7fff_ffff;
      else r = m[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat64(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Microprogram. The first sample runs from PC_INIT, every later one from PC_MAIN.
  localparam instr_t PROG [PROG_LEN] = '{
    // first sample: initial covariance and zero estimates
    mk(OP_SCL, A_RR, A_T, A_PW),
    mk(OP_MUL, A_T1, A_RR, A_T),
    mk(OP_MUL, A_RA, A_T1, A_HALF),
    mk(OP_MUL, A_T2, A_T1, A_T),
    mk(OP_MUL, A_AA, A_T2, A_THIRD),
    mk(OP_ADD, A_RB, A_ZERO, A_ZERO),
    mk(OP_ADD, A_AB, A_ZERO, A_ZERO),
    mk(OP_SCL, A_BB, A_T, A_PB),
    mk(OP_ADD, A_ER, A_ZERO, A_ZERO),
    mk(OP_ADD, A_EA, A_ZERO, A_ZERO),
    mk(OP_ADD, A_EB, A_ZERO, A_ZERO),
    mk(OP_LOAD, A_ZERO, A_ZERO, A_ZERO),
    // time update
    mk(OP_SCL, A_X, A_T, A_QW),
    mk(OP_MUL, A_T1, A_T, A_ER),
    mk(OP_ADD, A_EA, A_EA, A_T1),
    mk(OP_MUL, A_T1, A_RR, A_T),
    mk(OP_MUL, A_T1, A_T1, A_T),
    mk(OP_MUL, A_T2, A_T, A_RA),
    mk(OP_SCL, A_T2, A_T2, A_TWO),
    mk(OP_ADD, A_T1, A_T1, A_T2),
    mk(OP_ADD, A_T1, A_T1, A_AA),
    mk(OP_MUL, A_T3, A_X, A_T),
    mk(OP_MUL, A_T3, A_T3, A_T),
    mk(OP_MUL, A_T3, A_T3, A_THIRD),
    mk(OP_ADD, A_AA, A_T1, A_T3),
    mk(OP_MUL, A_T1, A_T, A_RR),
    mk(OP_ADD, A_T1, A_T1, A_RA),
    mk(OP_MUL, A_T2, A_X, A_T),
    mk(OP_MUL, A_T2, A_T2, A_HALF),
    mk(OP_ADD, A_RA, A_T1, A_T2),
    mk(OP_ADD, A_RR, A_RR, A_X),
    mk(OP_MUL, A_T1, A_T, A_RB),
    mk(OP_ADD, A_AB, A_T1, A_AB),
    mk(OP_MUL, A_T1, A_T, A_QB),
    mk(OP_ADD, A_BB, A_BB, A_T1),
    // angle measurement update
    mk(OP_ADD, A_D, A_AA, A_RTQ),
    mk(OP_DIV, A_GR, A_RA, A_D),
    mk(OP_DIV, A_GA, A_AA, A_D),
    mk(OP_DIV, A_GB, A_AB, A_D),
    mk(OP_SUB, A_E, A_Z, A_EA),
    mk(OP_MUL, A_T1, A_GR, A_E),
    mk(OP_ADD, A_ER, A_ER, A_T1),
    mk(OP_MUL, A_T1, A_GA, A_E),
    mk(OP_ADD, A_EA, A_EA, A_T1),
    mk(OP_MUL, A_T1, A_GB, A_E),
    mk(OP_ADD, A_EB, A_EB, A_T1),
    mk(OP_SUB, A_G1, A_GA, A_ONE),
    mk(OP_MUL, A_T1, A_GR, A_AA),
    mk(OP_SUB, A_X, A_RA, A_T1),
    mk(OP_MUL, A_T1, A_GR, A_GR),
    mk(OP_MUL, A_T2, A_T1, A_AA),
    mk(OP_ADD, A_N, A_RR, A_T2),
    mk(OP_SCL, A_T2, A_T1, A_RT),
    mk(OP_ADD, A_N, A_N, A_T2),
    mk(OP_SCL, A_T3, A_GR, A_TWO),
    mk(OP_MUL, A_T3, A_T3, A_RA),
    mk(OP_SUB, A_NRR, A_N, A_T3),
    mk(OP_MUL, A_T1, A_GR, A_GA),
    mk(OP_SCL, A_T1, A_T1, A_RT),
    mk(OP_MUL, A_U, A_G1, A_X),
    mk(OP_SUB, A_NRA, A_T1, A_U),
    mk(OP_MUL, A_T1, A_GB, A_X),
    mk(OP_SUB, A_N, A_RB, A_T1),
    mk(OP_MUL, A_T1, A_GR, A_AB),
    mk(OP_SUB, A_N, A_N, A_T1),
    mk(OP_MUL, A_T1, A_GR, A_GB),
    mk(OP_SCL, A_T1, A_T1, A_RT),
    mk(OP_ADD, A_NRB, A_N, A_T1),
    mk(OP_MUL, A_T1, A_GA, A_GA),
    mk(OP_SCL, A_T1, A_T1, A_RT),
    mk(OP_MUL, A_U, A_G1, A_G1),
    mk(OP_MUL, A_U, A_AA, A_U),
    mk(OP_ADD, A_NAA, A_T1, A_U),
    mk(OP_MUL, A_T1, A_GA, A_GB),
    mk(OP_SCL, A_T1, A_T1, A_RT),
    mk(OP_MUL, A_U, A_AB, A_G1),
    mk(OP_SUB, A_T1, A_T1, A_U),
    mk(OP_MUL, A_U, A_GB, A_AA),
    mk(OP_MUL, A_U, A_U, A_G1),
    mk(OP_ADD, A_NAB, A_T1, A_U),
    mk(OP_MUL, A_T2, A_GB, A_GB),
    mk(OP_MUL, A_T1, A_T2, A_AA),
    mk(OP_ADD, A_N, A_BB, A_T1),
    mk(OP_SCL, A_T1, A_T2, A_RT),
    mk(OP_ADD, A_N, A_N, A_T1),
    mk(OP_SCL, A_U, A_GB, A_TWO),
    mk(OP_MUL, A_U, A_U, A_AB),
    mk(OP_SUB, A_NBB, A_N, A_U),
    mk(OP_ANG, A_ZERO, A_EA, A_ZERO),
    // gyro measurement update
    mk(OP_SCL, A_T1, A_NRB, A_TWO),
    mk(OP_ADD, A_D, A_NRR, A_T1),
    mk(OP_ADD, A_D, A_D, A_NBB),
    mk(OP_ADD, A_D, A_D, A_RW),
    mk(OP_ADD, A_S, A_NRR, A_NRB),
    mk(OP_DIV, A_GR, A_S, A_D),
    mk(OP_ADD, A_S, A_NRA, A_NAB),
    mk(OP_DIV, A_GA, A_S, A_D),
    mk(OP_ADD, A_S, A_NRB, A_NBB),
    mk(OP_DIV, A_GB, A_S, A_D),
    mk(OP_SUB, A_E, A_W, A_ER),
    mk(OP_SUB, A_E, A_E, A_EB),
    mk(OP_MUL, A_T1, A_GR, A_E),
    mk(OP_ADD, A_ER, A_ER, A_T1),
    mk(OP_MUL, A_T1, A_GA, A_E),
    mk(OP_ADD, A_EA, A_EA, A_T1),
    mk(OP_MUL, A_T1, A_GB, A_E),
    mk(OP_ADD, A_EB, A_EB, A_T1),
    mk(OP_SUB, A_G1, A_GR, A_ONE),
    mk(OP_SUB, A_GB1, A_GB, A_ONE),
    mk(OP_MUL, A_T1, A_NRB, A_G1),
    mk(OP_MUL, A_U, A_GR, A_NBB),
    mk(OP_ADD, A_X, A_T1, A_U),
    mk(OP_MUL, A_T1, A_NRR, A_G1),
    mk(OP_MUL, A_U, A_GR, A_NRB),
    mk(OP_ADD, A_Y, A_T1, A_U),
    mk(OP_MUL, A_GA2, A_GA, A_GA),
    mk(OP_MUL, A_T1, A_GR, A_GR),
    mk(OP_MUL, A_T1, A_T1, A_RW),
    mk(OP_MUL, A_U, A_GR, A_X),
    mk(OP_ADD, A_T1, A_T1, A_U),
    mk(OP_MUL, A_U, A_G1, A_Y),
    mk(OP_ADD, A_RR, A_T1, A_U),
    mk(OP_MUL, A_T1, A_GA, A_X),
    mk(OP_MUL, A_U, A_NRA, A_G1),
    mk(OP_SUB, A_T1, A_T1, A_U),
    mk(OP_MUL, A_U, A_GA, A_Y),
    mk(OP_ADD, A_T1, A_T1, A_U),
    mk(OP_MUL, A_U, A_GR, A_NAB),
    mk(OP_SUB, A_T1, A_T1, A_U),
    mk(OP_MUL, A_U, A_GR, A_GA),
    mk(OP_MUL, A_U, A_U, A_RW),
    mk(OP_ADD, A_RA, A_T1, A_U),
    mk(OP_MUL, A_T1, A_GB, A_Y),
    mk(OP_MUL, A_U, A_GB1, A_X),
    mk(OP_ADD, A_T1, A_T1, A_U),
    mk(OP_MUL, A_U, A_GR, A_GB),
    mk(OP_MUL, A_U, A_U, A_RW),
    mk(OP_ADD, A_RB, A_T1, A_U),
    mk(OP_MUL, A_T1, A_GA2, A_NBB),
    mk(OP_ADD, A_T1, A_NAA, A_T1),
    mk(OP_MUL, A_U, A_GA2, A_NRB),
    mk(OP_SCL, A_U, A_U, A_TWO),
    mk(OP_ADD, A_T1, A_T1, A_U),
    mk(OP_MUL, A_U, A_GA2, A_NRR),
    mk(OP_ADD, A_T1, A_T1, A_U),
    mk(OP_MUL, A_U, A_GA2, A_RW),
    mk(OP_ADD, A_T1, A_T1, A_U),
    mk(OP_SCL, A_G2, A_GA, A_TWO),
    mk(OP_MUL, A_U, A_G2, A_NAB),
    mk(OP_SUB, A_T1, A_T1, A_U),
    mk(OP_MUL, A_U, A_G2, A_NRA),
    mk(OP_SUB, A_AA, A_T1, A_U),
    mk(OP_MUL, A_T1, A_GA, A_NBB),
    mk(OP_SUB, A_T1, A_T1, A_NAB),
    mk(OP_MUL, A_U, A_GA, A_NRB),
    mk(OP_ADD, A_T1, A_T1, A_U),
    mk(OP_MUL, A_T1, A_GB1, A_T1),
    mk(OP_MUL, A_V, A_GA, A_NRB),
    mk(OP_SUB, A_V, A_V, A_NRA),
    mk(OP_MUL, A_U, A_GA, A_NRR),
    mk(OP_ADD, A_V, A_V, A_U),
    mk(OP_MUL, A_V, A_GB, A_V),
    mk(OP_ADD, A_T1, A_T1, A_V),
    mk(OP_MUL, A_U, A_GA, A_GB),
    mk(OP_MUL, A_U, A_U, A_RW),
    mk(OP_ADD, A_AB, A_T1, A_U),
    mk(OP_MUL, A_T1, A_GB, A_GB),
    mk(OP_MUL, A_T1, A_T1, A_RW),
    mk(OP_MUL, A_U, A_NRB, A_GB1),
    mk(OP_MUL, A_V, A_GB, A_NRR),
    mk(OP_ADD, A_U, A_U, A_V),
    mk(OP_MUL, A_U, A_GB, A_U),
    mk(OP_ADD, A_T1, A_T1, A_U),
    mk(OP_MUL, A_U, A_NBB, A_GB1),
    mk(OP_MUL, A_V, A_GB, A_NRB),
    mk(OP_ADD, A_U, A_U, A_V),
    mk(OP_MUL, A_U, A_GB1, A_U),
    mk(OP_ADD, A_BB, A_T1, A_U),
    mk(OP_FIN, A_ZERO, A_ER, A_ZERO)
  };

endpackage

// File: design/angle_rate_bias_kalman_filter.sv
`timescale 1ns / 1ps
// The first sample after reset only loads the filter and yields no result; every later sample
// runs 167 micro-ops, six of them 48-step divisions, all through one shared arithmetic unit.
// Throughput: one sample at a time; the input side is ready only while the sequencer is idle.
// Reset (rst, synchronous, active high) restores the register defaults, clears the started flag
// and empties the output register; the estimates and covariance are loaded by the first sample.

module angle_rate_bias_kalman_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] angle_measurement, [63:32] rate_measurement
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // [31:0] angle_estimate, [63:32] rate_estimate
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  // Configuration registers.
  logic [30:0] gyro_noise;
  logic [7:0]  angle_noise;
  logic [15:0] accel_process_noise;
  logic [30:0] bias_process_noise;
  logic [7:0]  rate_initial_uncertainty;
  logic [7:0]  bias_initial_uncertainty;
  logic [16:0] sample_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_noise               <= 31'd655;
      angle_noise              <= 8'd50;
      accel_process_noise      <= 16'd10;
      bias_process_noise       <= 31'd66;
      rate_initial_uncertainty <= 8'd10;
      bias_initial_uncertainty <= 8'd60;
      sample_period            <= 17'd655;
    end else if (cfg_we) begin
      case (cfg_index)
        arbkf_pkg::CFG_GYRO_NOISE:  gyro_noise <= cfg_data;
        arbkf_pkg::CFG_ANGLE_NOISE: angle_noise <= cfg_data[7:0];
        arbkf_pkg::CFG_ACCEL_NOISE: accel_process_noise <= cfg_data[15:0];
        arbkf_pkg::CFG_BIAS_NOISE:  bias_process_noise <= cfg_data;
        arbkf_pkg::CFG_RATE_INIT:   rate_initial_uncertainty <= cfg_data[7:0];
        arbkf_pkg::CFG_BIAS_INIT:   bias_initial_uncertainty <= cfg_data[7:0];
        arbkf_pkg::CFG_SAMPLE_PER:  sample_period <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and datapath state.
  arbkf_pkg::seq_state_t state, state_next;
  logic                       started;
  logic [arbkf_pkg::PC_W-1:0] pc;
  arbkf_pkg::instr_t          cur;
  logic signed [31:0]         opa;
  logic signed [31:0]         opb;
  logic signed [63:0]         acc;
  logic [31:0]                z_in;
  logic [31:0]                w_in;
  logic [31:0]                angle_hold;

  // Divider: restoring shift-subtract, one quotient bit per cycle.
  logic [47:0]                 dnum;
  logic [31:0]                 drem;
  logic [31:0]                 dden;
  logic                        dneg;
  logic [arbkf_pkg::DIV_W-1:0] dcnt;
  logic [32:0]                 dtrial;
  logic [31:0]                 mag_a;
  logic [31:0]                 mag_b;

  // Register file holding the estimates, covariance and scratch values.
  logic [31:0] regs [arbkf_pkg::NUM_REGS];

  logic        accept;
  logic        slot_free;
  logic [31:0] wb_val;
  logic [63:0] mul_mag;
  logic [63:0] mul_rnd;

  assign s_axis_tready = (state == arbkf_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !m_axis_tvalid || m_axis_tready;

  // Operands that do not live in the register file: configuration, constants and inputs.
  function automatic logic [31:0] special_val(input arbkf_pkg::addr_t addr,
                                              input logic [31:0] z, input logic [31:0] w,
                                              input logic [16:0] t, input logic [15:0] qw,
                                              input logic [7:0] rt, input logic [30:0] rw,
                                              input logic [30:0] qb, input logic [7:0] pw,
                                              input logic [7:0] pb);
    logic [31:0] r;
    case (addr)
      arbkf_pkg::A_T:     r = {15'd0, t};
      arbkf_pkg::A_QW:    r = {16'd0, qw};
      arbkf_pkg::A_RT:    r = {24'd0, rt};
      arbkf_pkg::A_RTQ:   r = {8'd0, rt, 16'd0};
      arbkf_pkg::A_RW:    r = {1'b0, rw};
      arbkf_pkg::A_QB:    r = {1'b0, qb};
      arbkf_pkg::A_PW:    r = {24'd0, pw};
      arbkf_pkg::A_PB:    r = {24'd0, pb};
      arbkf_pkg::A_ONE:   r = arbkf_pkg::Q_ONE;
      arbkf_pkg::A_HALF:  r = arbkf_pkg::Q_HALF;
      arbkf_pkg::A_THIRD: r = arbkf_pkg::Q_THIRD;
      arbkf_pkg::A_TWO:   r = 32'd2;
      arbkf_pkg::A_Z:     r = z;
      arbkf_pkg::A_W:     r = w;
      default:            r = 32'd0;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arbkf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      arbkf_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_next = arbkf_pkg::ST_FETCH;
      end
      arbkf_pkg::ST_FETCH: state_next = arbkf_pkg::ST_EXEC;
      arbkf_pkg::ST_EXEC: begin
        case (cur.op)
          arbkf_pkg::OP_DIV:  state_next = (opb == 32'sd0) ? arbkf_pkg::ST_WB
                                                           : arbkf_pkg::ST_DIV;
          arbkf_pkg::OP_ANG:  state_next = arbkf_pkg::ST_FETCH;
          arbkf_pkg::OP_LOAD: state_next = arbkf_pkg::ST_IDLE;
          arbkf_pkg::OP_FIN:  state_next = slot_free ? arbkf_pkg::ST_IDLE
                                                     : arbkf_pkg::ST_EXEC;
          default:            state_next = arbkf_pkg::ST_WB;
        endcase
      end
      arbkf_pkg::ST_DIV: begin
        if (dcnt == arbkf_pkg::DIV_W'(arbkf_pkg::DIV_STEPS - 1)) state_next = arbkf_pkg::ST_WB;
      end
      arbkf_pkg::ST_WB: state_next = arbkf_pkg::ST_FETCH;
      default: state_next = arbkf_pkg::ST_IDLE;
    endcase
  end

  // Write-back conversion: rounding of products and saturation of whatever the unit produced.
  always_comb begin
    mul_mag = acc[63] ? 64'(-acc) : 64'(acc);
    mul_rnd = mul_mag + 64'd32768;
    case (cur.op)
      arbkf_pkg::OP_MUL: wb_val = arbkf_pkg::from_mag(acc[63], mul_rnd[63:16]);
      arbkf_pkg::OP_DIV: wb_val = arbkf_pkg::from_mag(dneg, dnum);
      default:           wb_val = arbkf_pkg::sat64(acc);
    endcase
  end

  assign mag_a  = opa[31] ? (~opa + 32'd1) : opa;
  assign mag_b  = opb[31] ? (~opb + 32'd1) : opb;
  assign dtrial = {drem, dnum[47]};

  always_ff @(posedge clk) begin
    if (accept) begin
      z_in <= s_axis_tdata[31:0];
      w_in <= s_axis_tdata[63:32];
      pc   <= started ? arbkf_pkg::PC_MAIN : arbkf_pkg::PC_INIT;
    end
    case (state)
      arbkf_pkg::ST_FETCH: begin
        // Register file read and operand selection, both registered.
        cur <= arbkf_pkg::PROG[pc];
        opa <= (arbkf_pkg::PROG[pc].a >= arbkf_pkg::A_SPECIAL)
             ? special_val(arbkf_pkg::PROG[pc].a, z_in, w_in, sample_period,
                           accel_process_noise, angle_noise, gyro_noise,
                           bias_process_noise, rate_initial_uncertainty,
                           bias_initial_uncertainty)
             : regs[arbkf_pkg::PROG[pc].a];
        opb <= (arbkf_pkg::PROG[pc].b >= arbkf_pkg::A_SPECIAL)
             ? special_val(arbkf_pkg::PROG[pc].b, z_in, w_in, sample_period,
                           accel_process_noise, angle_noise, gyro_noise,
                           bias_process_noise, rate_initial_uncertainty,
                           bias_initial_uncertainty)
             : regs[arbkf_pkg::PROG[pc].b];
      end
      arbkf_pkg::ST_EXEC: begin
        case (cur.op)
          arbkf_pkg::OP_ADD: acc <= 64'(opa) + 64'(opb);
          arbkf_pkg::OP_SUB: acc <= 64'(opa) - 64'(opb);
          arbkf_pkg::OP_MUL,
          arbkf_pkg::OP_SCL: acc <= opa * opb;
          arbkf_pkg::OP_DIV: begin
            // Numerator carries half the divisor so the quotient rounds to nearest.
            dnum <= (opb == 32'sd0) ? 48'd0 : ({mag_a, 16'd0} + 48'(mag_b >> 1));
            dneg <= (opb == 32'sd0) ? 1'b0 : (opa[31] ^ opb[31]);
            dden <= mag_b;
            drem <= 32'd0;
            dcnt <= '0;
          end
          arbkf_pkg::OP_ANG: begin
            angle_hold <= opa;
            pc         <= pc + arbkf_pkg::PC_W'(1);
          end
          default: begin
          end
        endcase
      end
      arbkf_pkg::ST_DIV: begin
        if (dtrial >= {1'b0, dden}) begin
          drem <= 32'(dtrial - {1'b0, dden});
          dnum <= {dnum[46:0], 1'b1};
        end else begin
          drem <= dtrial[31:0];
          dnum <= {dnum[46:0], 1'b0};
        end
        dcnt <= dcnt + arbkf_pkg::DIV_W'(1);
      end
      arbkf_pkg::ST_WB: begin
        regs[cur.dst[arbkf_pkg::ADDR_W-1:0]] <= wb_val;
        pc <= pc + arbkf_pkg::PC_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Started flag and the output register. The output holds a finished result while the
  // sequencer goes back to idle, so a new sample may be transferred before it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == arbkf_pkg::ST_EXEC && cur.op == arbkf_pkg::OP_LOAD) started <= 1'b1;
      if (state == arbkf_pkg::ST_EXEC && cur.op == arbkf_pkg::OP_FIN && slot_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == arbkf_pkg::ST_EXEC && cur.op == arbkf_pkg::OP_FIN && slot_free) begin
      m_axis_tdata <= {opa, angle_hold};
    end
  end

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == arbkf_pkg::ST_EXEC && cur.op == arbkf_pkg::OP_FIN))
    else $error("result raised without a finishing micro-op");

  a_wb_in_file: assert property (@(posedge clk) disable iff (rst)
    state == arbkf_pkg::ST_WB |-> cur.dst < arbkf_pkg::ADDR_W'(arbkf_pkg::NUM_REGS))
    else $error("write-back outside the register file");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == arbkf_pkg::ST_DIV |-> dcnt < arbkf_pkg::DIV_W'(arbkf_pkg::DIV_STEPS))
    else $error("divider ran past its step count");

  a_first_init: assert property (@(posedge clk) disable iff (rst)
    accept && !started |=> pc == arbkf_pkg::PC_INIT)
    else $error("first sample did not start the initial load");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the angle/rate/bias Kalman filter. Samples are queued
// by the stimulus process, handed to the block by a falling-edge driver, and
// every accepted sample is run through a bit-exact fixed-point filter model kept
// here. Results are compared field by field with the oldest predicted estimate.
module testbench;

  localparam int QMAX = 32'sh7fff_ffff;
  localparam int QMIN = 32'sh8000_0000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1200;
  // An index past the end of the register list.
  localparam logic [2:0] CFG_UNUSED_INDEX = 3'd7;

  typedef struct {
    int angle;
    int rate;
  } sample_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [30:0] cfg_data;

  angle_rate_bias_kalman_filter u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Samples waiting to be sent, and the estimates the filter model expects back.
  sample_t pending_samples[$];
  sample_t expected_estimates[$];
  int error_count;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;
  // Registered flag, set at a rising edge at which an input transfer happened.
  logic in_fire;

  // Local copy of the tuning registers.
  int gyro_noise_q;
  longint angle_noise_w;
  longint accel_noise_w;
  int bias_noise_q;
  longint rate_init_w;
  longint bias_init_w;
  int period_q;

  // Filter state: started flag, estimates and the six covariance entries.
  bit filter_started;
  int est_rate, est_angle, est_bias;
  int p_rr, p_ra, p_rb, p_aa, p_ab, p_bb;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Saturating Q16.16 arithmetic.
  function automatic int q_sat(input longint v);
    if (v > longint'(QMAX)) return QMAX;
    if (v < longint'(QMIN)) return QMIN;
    return int'(v);
  endfunction

  function automatic int q_from_mag(input bit neg, input longint unsigned m);
    if (neg) begin
      if (m > 64'd2147483648) return QMIN;
      return q_sat(-longint'(m));
    end
    if (m > 64'd2147483647) return QMAX;
    return int'(m);
  endfunction

  function automatic int q_add(input int a, input int b);
    return q_sat(longint'(a) + longint'(b));
  endfunction

  function automatic int q_sub(input int a, input int b);
    return q_sat(longint'(a) - longint'(b));
  endfunction

  function automatic int q_scale(input int a, input longint n);
    return q_sat(longint'(a) * n);
  endfunction

  function automatic int q_mul(input int a, input int b);
    longint p;
    longint unsigned m;
    p = longint'(a) * longint'(b);
    m = (p < 0) ? longint'(-p) : p;
    return q_from_mag(p < 0, (m + 64'd32768) >> 16);
  endfunction

  function automatic int q_div(input int a, input int b);
    longint unsigned ma, mb;
    if (b == 0) return 0;
    ma = (a < 0) ? -longint'(a) : longint'(a);
    mb = (b < 0) ? -longint'(b) : longint'(b);
    return q_from_mag((a < 0) != (b < 0), ((ma << 16) + mb / 2) / mb);
  endfunction

  // Runs one sample through the filter. Returns 1 when an estimate comes out.
  function automatic bit filter_sample(input int z, input int w, output sample_t est);
    int t, rr, ra, rb, aa, ab, bb, er, ea, eb, d, gr, ga, gb, e, gr1, ga1, gb1;
    int x, y, rwq, pwt, ga2;
    int nrr, nra, nrb, naa, nab, nbb;
    longint rt, qw;
    t = period_q;
    rwq = gyro_noise_q;
    rt = angle_noise_w;
    qw = accel_noise_w;
    est = '{0, 0};
    if (!filter_started) begin
      pwt = q_scale(t, rate_init_w);
      p_rr = pwt;
      p_ra = q_mul(q_mul(pwt, t), int'(arbkf_pkg::Q_HALF));
      p_rb = 0;
      p_aa = q_mul(q_mul(q_mul(pwt, t), t), int'(arbkf_pkg::Q_THIRD));
      p_ab = 0;
      p_bb = q_scale(t, bias_init_w);
      est_rate = 0;
      est_angle = 0;
      est_bias = 0;
      filter_started = 1'b1;
      return 1'b0;
    end
    rr = p_rr; ra = p_ra; rb = p_rb; aa = p_aa; ab = p_ab; bb = p_bb;
    er = est_rate; ea = est_angle; eb = est_bias;

    // Prediction over one sample period.
    x = q_scale(t, qw);
    ea = q_add(ea, q_mul(t, er));
    aa = q_add(q_add(q_add(q_mul(q_mul(rr, t), t), q_scale(q_mul(t, ra), 2)), aa),
               q_mul(q_mul(q_mul(x, t), t), int'(arbkf_pkg::Q_THIRD)));
    ra = q_add(q_add(q_mul(t, rr), ra), q_mul(q_mul(x, t), int'(arbkf_pkg::Q_HALF)));
    rr = q_add(rr, x);
    ab = q_add(q_mul(t, rb), ab);
    bb = q_add(bb, q_mul(t, bias_noise_q));

    // Accelerometer angle correction.
    d = q_add(aa, int'(rt << 16));
    gr = q_div(ra, d); ga = q_div(aa, d); gb = q_div(ab, d);
    e = q_sub(z, ea);
    er = q_add(er, q_mul(gr, e));
    ea = q_add(ea, q_mul(ga, e));
    eb = q_add(eb, q_mul(gb, e));
    ga1 = q_sub(ga, int'(arbkf_pkg::Q_ONE));
    x = q_sub(ra, q_mul(gr, aa));
    nrr = q_sub(q_add(q_add(rr, q_mul(q_mul(gr, gr), aa)), q_scale(q_mul(gr, gr), rt)),
                q_mul(q_scale(gr, 2), ra));
    nra = q_sub(q_scale(q_mul(gr, ga), rt), q_mul(ga1, x));
    nrb = q_add(q_sub(q_sub(rb, q_mul(gb, x)), q_mul(gr, ab)), q_scale(q_mul(gr, gb), rt));
    naa = q_add(q_scale(q_mul(ga, ga), rt), q_mul(aa, q_mul(ga1, ga1)));
    nab = q_add(q_sub(q_scale(q_mul(ga, gb), rt), q_mul(ab, ga1)), q_mul(q_mul(gb, aa), ga1));
    nbb = q_sub(q_add(q_add(bb, q_mul(q_mul(gb, gb), aa)), q_scale(q_mul(gb, gb), rt)),
                q_mul(q_scale(gb, 2), ab));
    rr = nrr; ra = nra; rb = nrb; aa = naa; ab = nab; bb = nbb;
    est.angle = ea;

    // Gyro correction; the gyro sees rate plus bias.
    d = q_add(q_add(q_add(rr, q_scale(rb, 2)), bb), rwq);
    gr = q_div(q_add(rr, rb), d);
    ga = q_div(q_add(ra, ab), d);
    gb = q_div(q_add(rb, bb), d);
    e = q_sub(q_sub(w, er), eb);
    er = q_add(er, q_mul(gr, e));
    ea = q_add(ea, q_mul(ga, e));
    eb = q_add(eb, q_mul(gb, e));
    gr1 = q_sub(gr, int'(arbkf_pkg::Q_ONE));
    gb1 = q_sub(gb, int'(arbkf_pkg::Q_ONE));
    x = q_add(q_mul(rb, gr1), q_mul(gr, bb));
    y = q_add(q_mul(rr, gr1), q_mul(gr, rb));
    ga2 = q_mul(ga, ga);
    nrr = q_add(q_add(q_mul(q_mul(gr, gr), rwq), q_mul(gr, x)), q_mul(gr1, y));
    nra = q_add(q_sub(q_add(q_sub(q_mul(ga, x), q_mul(ra, gr1)), q_mul(ga, y)), q_mul(gr, ab)),
                q_mul(q_mul(gr, ga), rwq));
    nrb = q_add(q_add(q_mul(gb, y), q_mul(gb1, x)), q_mul(q_mul(gr, gb), rwq));
    naa = q_sub(q_sub(q_add(q_add(q_add(q_add(aa, q_mul(ga2, bb)), q_scale(q_mul(ga2, rb), 2)),
                                      q_mul(ga2, rr)), q_mul(ga2, rwq)),
                      q_mul(q_scale(ga, 2), ab)), q_mul(q_scale(ga, 2), ra));
    nab = q_add(q_add(q_mul(gb1, q_add(q_sub(q_mul(ga, bb), ab), q_mul(ga, rb))),
                      q_mul(gb, q_add(q_sub(q_mul(ga, rb), ra), q_mul(ga, rr)))),
                q_mul(q_mul(ga, gb), rwq));
    nbb = q_add(q_add(q_mul(q_mul(gb, gb), rwq),
                      q_mul(gb, q_add(q_mul(rb, gb1), q_mul(gb, rr)))),
                q_mul(gb1, q_add(q_mul(bb, gb1), q_mul(gb, rb))));
    p_rr = nrr; p_ra = nra; p_rb = nrb; p_aa = naa; p_ab = nab; p_bb = nbb;
    est_rate = er; est_angle = ea; est_bias = eb;
    est.rate = er;
    return 1'b1;
  endfunction

  // Input driver: a new sample is presented only when the previous transfer is done.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
      if (!s_axis_tvalid || in_fire) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
          s_axis_tdata <= {pending_samples[0].rate, pending_samples[0].angle};
          s_axis_tvalid <= 1'b1;
          void'(pending_samples.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts on every input transfer and checks every output transfer.
  always @(posedge clk) begin
    sample_t est, want;
    if (rst) begin
      quiet_cycles <= 0;
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        if (filter_sample(int'(s_axis_tdata[31:0]), int'(s_axis_tdata[63:32]), est))
          expected_estimates.push_back(est);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_estimates.size() == 0) begin
          $error("unexpected estimate %h", m_axis_tdata);
          error_count++;
        end else begin
          want = expected_estimates.pop_front();
          if (int'(m_axis_tdata[31:0]) != want.angle) begin
            $error("angle_estimate: expected %0d, got %0d", want.angle,
                   int'(m_axis_tdata[31:0]));
            error_count++;
          end
          if (int'(m_axis_tdata[63:32]) != want.rate) begin
            $error("rate_estimate: expected %0d, got %0d", want.rate,
                   int'(m_axis_tdata[63:32]));
            error_count++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // One register write at a falling edge; the local copy follows at once.
  task automatic write_reg(input logic [2:0] index, input logic [30:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    case (index)
      arbkf_pkg::CFG_GYRO_NOISE: gyro_noise_q = int'(value);
      arbkf_pkg::CFG_ANGLE_NOISE: angle_noise_w = longint'(value[7:0]);
      arbkf_pkg::CFG_ACCEL_NOISE: accel_noise_w = longint'(value[15:0]);
      arbkf_pkg::CFG_BIAS_NOISE: bias_noise_q = int'(value);
      arbkf_pkg::CFG_RATE_INIT: rate_init_w = longint'(value[7:0]);
      arbkf_pkg::CFG_BIAS_INIT: bias_init_w = longint'(value[7:0]);
      arbkf_pkg::CFG_SAMPLE_PER: period_q = int'(value[16:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_tuning(input int gn, input int an, input int acn, input int bn,
                              input int ri, input int bi, input int per);
    write_reg(arbkf_pkg::CFG_GYRO_NOISE, 31'(gn));
    write_reg(arbkf_pkg::CFG_ANGLE_NOISE, 31'(an));
    write_reg(arbkf_pkg::CFG_ACCEL_NOISE, 31'(acn));
    write_reg(arbkf_pkg::CFG_BIAS_NOISE, 31'(bn));
    write_reg(arbkf_pkg::CFG_RATE_INIT, 31'(ri));
    write_reg(arbkf_pkg::CFG_BIAS_INIT, 31'(bi));
    write_reg(arbkf_pkg::CFG_SAMPLE_PER, 31'(per));
  endtask

  task automatic queue_sample(input int angle, input int rate);
    pending_samples.push_back('{angle, rate});
  endtask

  // Mostly a slowly swinging angle with a consistent gyro rate and sensor noise;
  // the rest is full-range noise and the saturation corners.
  task automatic queue_random(input int count);
    int angle, rate, kind;
    angle = $urandom_range(1310720) - 655360;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      rate = $urandom_range(262144) - 131072;
      if (kind < 70) begin
        angle = angle + rate / 100;
        queue_sample(angle + $urandom_range(8192) - 4096, rate + $urandom_range(4096) - 2048);
      end else if (kind < 90) begin
        queue_sample($urandom, $urandom);
      end else begin
        queue_sample($urandom_range(1) ? QMAX : QMIN, $urandom_range(1) ? QMAX : QMIN);
      end
    end
  endtask

  // Lets the queued samples drain, then waits out any sample still in flight.
  task automatic drain_phase(input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    wait (pending_samples.size() == 0 && !s_axis_tvalid && expected_estimates.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int idle_modes[4];
    int stall_modes[4];
    idle_modes = '{0, 81, 0, 14};
    stall_modes = '{0, 0, 81, 14};
    error_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    filter_started = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gyro_noise_q = 655;
    angle_noise_w = 50;
    accel_noise_w = 10;
    bias_noise_q = 66;
    rate_init_w = 10;
    bias_init_w = 60;
    period_q = 655;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // The initial uncertainties only act on the first sample, so they are set first.
    write_tuning(655, 50, 10, 66, 200, 255, 655);
    // An index past the register list must be ignored.
    write_reg(CFG_UNUSED_INDEX, 31'($urandom));

    // Directed part: the first sample only loads the filter, then field corners.
    queue_sample(0, 0);
    queue_sample(0, 0);
    queue_sample(65536, 6553);
    queue_sample(QMAX, QMAX);
    queue_sample(QMAX, QMAX);
    queue_sample(QMIN, QMIN);
    queue_sample(QMIN, QMAX);
    queue_sample(QMAX, QMIN);
    queue_sample(-1, -1);
    queue_sample(1, 1);
    queue_sample(32'sh5555_5555, 32'shaaaa_aaaa);
    queue_sample(32'shaaaa_aaaa, 32'sh5555_5555);
    queue_sample(-65536, 13107);
    queue_sample(0, 0);
    queue_random(120);
    drain_phase(0, 0);

    // Largest settings everywhere: divisors and products saturate.
    write_tuning(32'h7fff_ffff, 255, 65535, 32'h7fff_ffff, 255, 255, 131071);
    queue_sample(QMAX, QMIN);
    queue_sample(QMIN, QMAX);
    queue_sample(0, 0);
    queue_random(130);
    drain_phase(81, 0);

    // All zero: a zero period freezes the prediction and zero divisors give zero gain.
    write_tuning(0, 0, 0, 0, 0, 0, 0);
    queue_sample(0, 0);
    queue_sample(QMAX, QMAX);
    queue_random(100);
    drain_phase(0, 81);

    // One full second per sample with quiet sensors.
    write_tuning(1, 0, 0, 1, 1, 1, 65536);
    queue_random(120);
    drain_phase(14, 14);

    // Random tunings for the rest of the run, rotating through the idling modes.
    for (int ph = 0; ph < 4; ph++) begin
      write_tuning($urandom_range(1) ? $urandom_range(32'h7fff_ffff) : $urandom_range(65536),
                   $urandom_range(255), $urandom_range(1) ? $urandom_range(65535)
                                                          : $urandom_range(100),
                   $urandom_range(1) ? $urandom_range(32'h7fff_ffff) : $urandom_range(1000),
                   $urandom_range(255), $urandom_range(255),
                   $urandom_range(1) ? $urandom_range(1, 2000) : $urandom_range(131071));
      write_reg(CFG_UNUSED_INDEX, 31'($urandom));
      queue_random(120);
      drain_phase(idle_modes[ph], stall_modes[ph]);
    end

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
